// File: rtl/legendre_polynomial_series_assert.svh
// Assertion macros used by the RTL core (lps_core).
`ifndef LEGENDRE_POLYNOMIAL_SERIES_ASSERT_SVH
`define LEGENDRE_POLYNOMIAL_SERIES_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define LPS_ASSERT_NOW(lbl, ck, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define LPS_ASSERT_NEXT(lbl, ck, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/lps_pkg.sv
package lps_pkg;

  localparam logic [5:0] MAX_ORDER = 6'd31;

  localparam logic signed [17:0] ONE_Q16     = 18'sd65536;
  localparam logic signed [17:0] NEG_ONE_Q16 = -18'sd65536;

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // round(2^20 / n), ties up; entries for n < 2 are never used
  localparam logic [19:0] RECIP_Q20 [32] = '{
    20'd0,      20'd0,      20'd524288, 20'd349525,
    20'd262144, 20'd209715, 20'd174763, 20'd149797,
    20'd131072, 20'd116508, 20'd104858, 20'd95325,
    20'd87381,  20'd80660,  20'd74898,  20'd69905,
    20'd65536,  20'd61681,  20'd58254,  20'd55188,
    20'd52429,  20'd49932,  20'd47663,  20'd45590,
    20'd43691,  20'd41943,  20'd40330,  20'd38836,
    20'd37449,  20'd36158,  20'd34953,  20'd33825
  };

  typedef struct packed {
    logic signed [17:0] x;
    logic [4:0]         top;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EMIT,
    ST_MUL,
    ST_PROD,
    ST_LO,
    ST_HI,
    ST_FIN
  } core_state_t;

endpackage

// File: rtl/lps_fifo.sv
module lps_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  lps_pkg::item_t      push_item,
  input  logic                pop,
  output lps_pkg::item_t      pop_item,
  output lps_pkg::fifo_stat_t stat
);

  lps_pkg::item_t                     mem_r [lps_pkg::FIFO_DEPTH];
  logic [lps_pkg::FIFO_PTR_W-1:0]     wr_ptr_r;
  logic [lps_pkg::FIFO_PTR_W-1:0]     rd_ptr_r;
  logic [lps_pkg::FIFO_CNT_W-1:0]     count_r;
  logic [lps_pkg::FIFO_CNT_W-1:0]     count_nxt;

  assign stat.full  = (count_r == lps_pkg::FIFO_CNT_W'(lps_pkg::FIFO_DEPTH));
  assign stat.empty = (count_r == '0);
  assign pop_item   = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == lps_pkg::FIFO_PTR_W'(lps_pkg::FIFO_DEPTH - 1)) ?
                    '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == lps_pkg::FIFO_PTR_W'(lps_pkg::FIFO_DEPTH - 1)) ?
                    '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// File: rtl/lps_front.sv
module lps_front (
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [17:0]  in_x_value,
  input  logic [4:0]          in_top_order,
  input  lps_pkg::fifo_stat_t stat,
  output logic                push,
  output lps_pkg::item_t      item
);

  assign in_stall = stat.full;
  assign push     = in_valid && !stat.full;

  // argument saturated to [-1,1], order clamped to the supported maximum
  always_comb begin
    if (in_x_value > lps_pkg::ONE_Q16) begin
      item.x = lps_pkg::ONE_Q16;
    end else if (in_x_value < lps_pkg::NEG_ONE_Q16) begin
      item.x = lps_pkg::NEG_ONE_Q16;
    end else begin
      item.x = in_x_value;
    end
    if ({1'b0, in_top_order} > lps_pkg::MAX_ORDER) begin
      item.top = lps_pkg::MAX_ORDER[4:0];
    end else begin
      item.top = in_top_order;
    end
  end

endmodule

// File: rtl/lps_core.sv
module lps_core (
  input  logic                clk,
  input  logic                rst_n,
  input  lps_pkg::fifo_stat_t stat,
  input  lps_pkg::item_t      item,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [4:0]          out_degree,
  output logic signed [17:0]  out_poly_value,
  output logic                out_last
);

  `include "legendre_polynomial_series_assert.svh"

  localparam logic signed [61:0] ROUND_HALF = 62'sh8_0000_0000;

  lps_pkg::core_state_t state_r;
  lps_pkg::core_state_t state_nxt;

  logic signed [17:0] x_r;
  logic [4:0]         tgt_r;
  logic [4:0]         n_r;
  logic signed [17:0] prev_r;
  logic signed [17:0] prev2_r;
  logic signed [17:0] res_r;
  logic signed [35:0] m1_r;
  logic signed [23:0] m2_r;
  logic signed [40:0] prod_r;
  logic [40:0]        plo_r;
  logic signed [40:0] phi_r;

  logic               out_valid_r;
  logic [4:0]         out_degree_r;
  logic signed [17:0] out_poly_r;
  logic               out_last_r;

  logic               out_free;
  logic               load_out;
  logic               is_last;
  logic [5:0]         coef_k;
  logic [4:0]         coef_nm1;
  logic [19:0]        recip;
  logic signed [61:0] sum;
  logic signed [25:0] rnd;
  logic signed [17:0] res_sat;

  assign out_free = !out_valid_r || !out_stall;
  assign is_last  = (n_r == tgt_r);
  assign coef_k   = {n_r, 1'b0} - 6'd1;
  assign coef_nm1 = n_r - 5'd1;
  assign recip    = lps_pkg::RECIP_Q20[n_r];

  // product * recip, split into low unsigned and high signed halves
  assign sum = $signed({phi_r, 21'd0}) + $signed({21'd0, plo_r}) + ROUND_HALF;
  assign rnd = $signed(sum[61:36]);

  always_comb begin
    if (rnd > 26'sd65536) begin
      res_sat = lps_pkg::ONE_Q16;
    end else if (rnd < -26'sd65536) begin
      res_sat = lps_pkg::NEG_ONE_Q16;
    end else begin
      res_sat = rnd[17:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lps_pkg::ST_IDLE: begin
        if (!stat.empty) begin
          state_nxt = lps_pkg::ST_EMIT;
        end
      end
      lps_pkg::ST_EMIT: begin
        if (out_free) begin
          if (is_last) begin
            state_nxt = lps_pkg::ST_IDLE;
          end else if (n_r == 5'd0) begin
            state_nxt = lps_pkg::ST_EMIT;
          end else begin
            state_nxt = lps_pkg::ST_MUL;
          end
        end
      end
      lps_pkg::ST_MUL:  state_nxt = lps_pkg::ST_PROD;
      lps_pkg::ST_PROD: state_nxt = lps_pkg::ST_LO;
      lps_pkg::ST_LO:   state_nxt = lps_pkg::ST_HI;
      lps_pkg::ST_HI:   state_nxt = lps_pkg::ST_FIN;
      lps_pkg::ST_FIN:  state_nxt = lps_pkg::ST_EMIT;
      default:          state_nxt = lps_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    load_out = 1'b0;
    case (state_r)
      lps_pkg::ST_IDLE: pop      = !stat.empty;
      lps_pkg::ST_EMIT: load_out = out_free;
      default: begin
        pop      = 1'b0;
        load_out = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lps_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      n_r         <= '0;
      tgt_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (pop) begin
        n_r   <= '0;
        tgt_r <= item.top;
      end else if (load_out) begin
        n_r <= n_r + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      x_r   <= item.x;
      res_r <= lps_pkg::ONE_Q16;
    end
    if (load_out) begin
      out_degree_r <= n_r;
      out_poly_r   <= res_r;
      out_last_r   <= is_last;
      prev2_r      <= prev_r;
      prev_r       <= res_r;
      if (n_r == 5'd0) begin
        res_r <= x_r;
      end
    end
    if (state_r == lps_pkg::ST_MUL) begin
      m1_r <= 36'(x_r) * 36'(prev_r);
      m2_r <= 24'($signed({1'b0, coef_nm1})) * 24'(prev2_r);
    end
    if (state_r == lps_pkg::ST_PROD) begin
      prod_r <= (41'($signed({1'b0, coef_k})) * 41'(m1_r)) -
                41'($signed({m2_r, 16'd0}));
    end
    if (state_r == lps_pkg::ST_LO) begin
      plo_r <= {20'd0, prod_r[20:0]} * {21'd0, recip};
    end
    if (state_r == lps_pkg::ST_HI) begin
      phi_r <= 41'($signed(prod_r[40:21])) * 41'($signed({1'b0, recip}));
    end
    if (state_r == lps_pkg::ST_FIN) begin
      res_r <= res_sat;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_degree     = out_degree_r;
  assign out_poly_value = out_poly_r;
  assign out_last       = out_last_r;

  `LPS_ASSERT_NOW(a_value_range, clk, rst_n, out_valid_r, (out_poly_r <= lps_pkg::ONE_Q16) && (out_poly_r >= lps_pkg::NEG_ONE_Q16), "result outside [-1,1]")
  `LPS_ASSERT_NOW(a_p0_is_one, clk, rst_n, out_valid_r && (out_degree_r == 5'd0), out_poly_r == lps_pkg::ONE_Q16, "P0 not one")
  `LPS_ASSERT_NOW(a_degree_bound, clk, rst_n, state_r != lps_pkg::ST_IDLE, n_r <= tgt_r, "degree ran past target")
  `LPS_ASSERT_NOW(a_pop_nonempty, clk, rst_n, pop, !stat.empty, "pop from empty queue")
  `LPS_ASSERT_NEXT(a_emit_waits, clk, rst_n, (state_r == lps_pkg::ST_EMIT) && out_valid_r && out_stall, state_r == lps_pkg::ST_EMIT, "step advanced while output blocked")

endmodule

// File: rtl/legendre_polynomial_series.sv
// Channel  Handshake              Payload
// in       in_valid / in_stall    in_x_value[17:0] s, in_top_order[4:0]
// out      out_valid / out_stall  out_degree[4:0], out_poly_value[17:0] s, out_last
//
// One argument gives top_order+1 results. It is taken from the queue, degrees 0 and 1
// are loaded straight into the output register, and every higher degree first passes
// the multiply chain (MUL, PROD, LO, HI, FIN) and then loads the output register.
// A two-entry queue takes new arguments while the recurrence runs.
// Reset is synchronous, active low; it empties the queue and the output.
// out_stall holds the result register; the recurrence waits at its next output load.
module legendre_polynomial_series (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [17:0] in_x_value,
  input  logic [4:0]         in_top_order,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [4:0]         out_degree,
  output logic signed [17:0] out_poly_value,
  output logic               out_last
);

  lps_pkg::fifo_stat_t stat;
  lps_pkg::item_t      push_item;
  lps_pkg::item_t      pop_item;
  logic                push;
  logic                pop;

  lps_front u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_x_value   (in_x_value),
    .in_top_order (in_top_order),
    .stat         (stat),
    .push         (push),
    .item         (push_item)
  );

  lps_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .stat      (stat)
  );

  lps_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .stat           (stat),
    .item           (pop_item),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_degree     (out_degree),
    .out_poly_value (out_poly_value),
    .out_last       (out_last)
  );

endmodule

// File: tb/sv/tb_legendre_polynomial_series.sv
module tb_legendre_polynomial_series;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 200;
  localparam int RANDOM_ITEMS = 446;
  localparam int CALM_FROM = 380;
  localparam int N_DIRECTED = 24;

  localparam int DIR_X [N_DIRECTED] = '{
    0, 65536, -65536, 32768, -32768, 131071, -131072, 65537,
    -65537, 1, -1, 45000, -12345, 65535, -65535, 20000,
    0, 65536, -65536, 98304, -98304, 7, 54321, -40000
  };
  localparam int DIR_TOP [N_DIRECTED] = '{
    0, 0, 0, 1, 1, 2, 2, 3,
    3, 31, 31, 31, 31, 5, 6, 31,
    31, 4, 7, 8, 9, 31, 16, 10
  };

  typedef struct {
    logic [4:0]         degree;
    logic signed [17:0] value;
    logic               last;
  } poly_term_t;

  class series_tracker;
    poly_term_t pending_terms[$];
    int         mismatch_count;

    function new();
      mismatch_count = 0;
    endfunction

    // Runs the three-term recurrence for one argument and queues every degree.
    function void note_argument(logic signed [17:0] x, logic [4:0] top);
      longint     hx, p1, p2, v, prod, recip;
      poly_term_t term;
      hx = x;
      if (hx > 65536) hx = 65536;
      if (hx < -65536) hx = -65536;
      p1 = 0;
      p2 = 0;
      for (int n = 0; n <= top; n++) begin
        if (n == 0) begin
          v = 65536;
        end else if (n == 1) begin
          v = hx;
        end else begin
          prod = longint'(2 * n - 1) * hx * p1 - longint'(n - 1) * p2 * 65536;
          recip = ((longint'(1) << 21) / n + 1) >>> 1;
          // arithmetic shift floors, so this rounds ties toward +inf
          v = (prod * recip + (longint'(1) << 35)) >>> 36;
          if (v > 65536) v = 65536;
          if (v < -65536) v = -65536;
        end
        p2 = p1;
        p1 = v;
        term.degree = n[4:0];
        term.value  = v[17:0];
        term.last   = (n == top);
        pending_terms.push_back(term);
      end
    endfunction

    function void check_term(logic [4:0] degree, logic signed [17:0] value, logic last);
      poly_term_t exp_term;
      if (pending_terms.size() == 0) begin
        $display("%0t: unexpected result degree %0d value %0d last %0b",
                 $time, degree, value, last);
        mismatch_count++;
        return;
      end
      exp_term = pending_terms.pop_front();
      if (degree !== exp_term.degree) begin
        $display("%0t: degree mismatch expected %0d actual %0d",
                 $time, exp_term.degree, degree);
        mismatch_count++;
      end
      if (value !== exp_term.value) begin
        $display("%0t: value mismatch at degree %0d expected %0d actual %0d",
                 $time, exp_term.degree, exp_term.value, value);
        mismatch_count++;
      end
      if (last !== exp_term.last) begin
        $display("%0t: last flag mismatch at degree %0d expected %0b actual %0b",
                 $time, exp_term.degree, exp_term.last, last);
        mismatch_count++;
      end
    endfunction

    function int pending();
      return pending_terms.size();
    endfunction
  endclass

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [17:0] in_x_value = '0;
  logic [4:0]         in_top_order = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [4:0]         out_degree;
  logic signed [17:0] out_poly_value;
  logic               out_last;

  series_tracker tracker;
  bit            idle_on = 1'b1;
  int            quiet_cycles = 0;

  legendre_polynomial_series dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_x_value     (in_x_value),
    .in_top_order   (in_top_order),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_degree     (out_degree),
    .out_poly_value (out_poly_value),
    .out_last       (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Monitor: inputs are noted before outputs are checked in the same cycle.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        tracker.note_argument(in_x_value, in_top_order);
      if (out_valid && !out_stall)
        tracker.check_term(out_degree, out_poly_value, out_last);
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("legendre_polynomial_series verification failed");
        $finish;
      end
    end
  end

  // Result side back-pressure in random bursts, with occasional calm stretches, while idle_on is set.
  initial begin
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        out_stall <= 1'b0;
      end else if (idle_on && $urandom_range(0, 29) == 0) begin
        repeat (40) @(posedge clk);
      end
    end
  end

  // Called at a clock edge; returns at the edge where the transaction is taken.
  task automatic send_argument(input logic signed [17:0] x, input logic [4:0] top);
    int gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_x_value   <= x;
    in_top_order <= top;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain_series();
    in_valid <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
  endtask

  initial begin
    logic signed [17:0] rx;
    logic [4:0]         rtop;
    int                 v;
    tracker = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIRECTED; i++) begin
      v = DIR_X[i];
      send_argument(v[17:0], DIR_TOP[i][4:0]);
    end
    drain_series();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == CALM_FROM) idle_on = 1'b0;
      if (i == 200) drain_series();
      case ($urandom_range(0, 9))
        0: rx = 18'($urandom);
        1: begin
          case ($urandom_range(0, 4))
            0: v = 65536;
            1: v = -65536;
            2: v = 0;
            3: v = 65535;
            default: v = -65535;
          endcase
          rx = v[17:0];
        end
        default: begin
          v = int'($urandom_range(0, 131072)) - 65536;
          rx = v[17:0];
        end
      endcase
      rtop = 5'($urandom_range(0, 31));
      send_argument(rx, rtop);
    end
    in_valid <= 1'b0;

    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.mismatch_count == 0 && tracker.pending() == 0)
      $display("legendre_polynomial_series verification clean");
    else
      $display("legendre_polynomial_series verification failed");
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/lps_pkg.sv
rtl/lps_fifo.sv
rtl/lps_front.sv
rtl/lps_core.sv
rtl/legendre_polynomial_series.sv
tb/sv/tb_legendre_polynomial_series.sv
